// ===== rtl/core/xild_pkg.sv =====
// Package for the x86 instruction length decoder: opcode table entries,
// phase encoding, and the opcode classification functions. No dependencies.
`default_nettype none
package xild_pkg;

   localparam logic [7:0] E_MR  = 8'h10;
   localparam logic [7:0] E_OS  = 8'h20;
   localparam logic [7:0] E_BAD = 8'h40;
   localparam logic [5:0] LEN_MAX = 6'd63;

   typedef enum logic [4:0] {
      PH_PREFIX = 5'b00001,
      PH_ESC    = 5'b00010,
      PH_MODRM  = 5'b00100,
      PH_SIB    = 5'b01000,
      PH_TAIL   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [5:0] length;
      logic       invalid;
   } rsp_type;

   // Entry of the one-byte opcode map.
   function automatic logic [7:0] one_byte_entry(input logic [7:0] b);
      logic [7:0] e;
      e = 8'd1;
      if (b < 8'h40) begin
         case (b[2:0])
            3'd4: e = 8'd2;
            3'd5: e = E_OS + 8'd1;
            3'd6, 3'd7: e = 8'd1;
            default: e = E_MR + 8'd1;
         endcase
         if (b == 8'h0F) e = 8'd0;
      end else begin
         case (b) inside
            8'h62, 8'h63: e = E_MR + 8'd1;
            8'h66: e = 8'd0;
            8'h67: e = E_BAD;
            8'h68: e = E_OS + 8'd1;
            8'h69: e = E_MR + E_OS + 8'd1;
            8'h6A: e = 8'd2;
            8'h6B: e = E_MR + 8'd2;
            [8'h70:8'h7F]: e = 8'd2;
            8'h80, 8'h82, 8'h83: e = E_MR + 8'd2;
            8'h81: e = E_MR + E_OS + 8'd1;
            [8'h84:8'h8F]: e = E_MR + 8'd1;
            8'h9A: e = E_OS + 8'd3;
            [8'hA0:8'hA3]: e = 8'd5;
            8'hA8: e = 8'd2;
            8'hA9: e = E_OS + 8'd1;
            [8'hB0:8'hB7]: e = 8'd2;
            [8'hB8:8'hBF]: e = E_OS + 8'd1;
            8'hC0, 8'hC1, 8'hC6: e = E_MR + 8'd2;
            8'hC2, 8'hCA: e = 8'd3;
            8'hC4, 8'hC5: e = E_MR + 8'd1;
            8'hC7: e = E_MR + E_OS + 8'd1;
            8'hC8: e = 8'd4;
            8'hCD: e = 8'd2;
            [8'hD0:8'hD3]: e = E_MR + 8'd1;
            8'hD4, 8'hD5: e = 8'd2;
            8'hD6: e = E_BAD;
            [8'hD8:8'hDF]: e = E_MR + 8'd1;
            [8'hE0:8'hE7]: e = 8'd2;
            8'hE8, 8'hE9: e = E_OS + 8'd1;
            8'hEA: e = E_OS + 8'd3;
            8'hEB: e = 8'd2;
            8'hF1: e = E_BAD;
            8'hF6, 8'hF7, 8'hFE, 8'hFF: e = E_MR + 8'd1;
            default: e = 8'd1;
         endcase
      end
      return e;
   endfunction

   // Entry of the map that follows the 0F escape.
   function automatic logic [7:0] escape_entry(input logic [7:0] b);
      logic [7:0] e;
      case (b) inside
         [8'h00:8'h03]: e = E_MR + 8'd2;
         8'h06, 8'h08, 8'h09: e = 8'd2;
         [8'h20:8'h24], 8'h26: e = 8'd3;
         [8'h30:8'h32]: e = 8'd2;
         [8'h80:8'h8F]: e = E_OS + 8'd2;
         [8'h90:8'h9F]: e = E_MR + 8'd2;
         8'hA0, 8'hA1, 8'hA2, 8'hA8, 8'hA9, 8'hAA: e = 8'd2;
         8'hA3, 8'hA5, 8'hAB, 8'hAD, 8'hAF: e = E_MR + 8'd2;
         8'hA4, 8'hAC, 8'hBA: e = E_MR + 8'd3;
         [8'hB0:8'hB7], [8'hBB:8'hBF], 8'hC0, 8'hC1: e = E_MR + 8'd2;
         [8'hC8:8'hCF]: e = 8'd2;
         default: e = E_BAD;
      endcase
      return e;
   endfunction

   function automatic logic [5:0] count_add(input logic [5:0] c, input logic [1:0] n);
      logic [6:0] s;
      s = {1'b0, c} + {5'd0, n};
      return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[5:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/xild_stream_if.sv =====
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; the payload type is a parameter of the interface.
`default_nettype none
interface xild_stream_if #(parameter type PAYLOAD_TYPE = logic [7:0]);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/xild_step.sv =====
// Combinational decode step: next decoder state and result from one byte.
// Depends on xild_pkg.
`default_nettype none
module xild_step (
   input  wire xild_pkg::phase_type cur_phase,
   input  wire logic [7:0]          code_byte,
   input  wire logic                cur_op16,
   input  wire logic [5:0]          cur_count,
   input  wire logic [4:0]          cur_rem,
   input  wire logic [1:0]          cur_g3,
   input  wire logic [1:0]          cur_mod,
   output xild_pkg::phase_type      nxt_phase,
   output logic                     nxt_op16,
   output logic [5:0]               nxt_count,
   output logic [4:0]               nxt_rem,
   output logic [1:0]               nxt_g3,
   output logic [1:0]               nxt_mod,
   output logic                     emit,
   output xild_pkg::rsp_type        result
);
   import xild_pkg::*;

   logic [7:0] entry;
   logic [5:0] opbytes;
   logic [5:0] rem;
   logic [5:0] osz;
   logic [1:0] md;
   logic [2:0] rm;
   logic       prefix;
   logic       done;

   always_comb begin
      nxt_phase = cur_phase;
      nxt_op16 = cur_op16;
      nxt_count = cur_count;
      nxt_rem = cur_rem;
      nxt_g3 = cur_g3;
      nxt_mod = cur_mod;
      emit = 1'b0;
      done = 1'b0;
      result = '{length: cur_count, invalid: 1'b0};
      osz = cur_op16 ? 6'd2 : 6'd4;
      md = code_byte[7:6];
      rm = code_byte[2:0];
      rem = {1'b0, cur_rem};
      entry = (cur_phase == PH_ESC) ? escape_entry(code_byte) : one_byte_entry(code_byte);
      opbytes = (cur_phase == PH_ESC) ? 6'd2 : 6'd1;
      prefix = (code_byte == 8'hF0) || (code_byte == 8'hF2) || (code_byte == 8'hF3) ||
               (code_byte == 8'h26) || (code_byte == 8'h2E) || (code_byte == 8'h36) ||
               (code_byte == 8'h3E) || (code_byte == 8'h64) || (code_byte == 8'h65);
      case (cur_phase)
         PH_MODRM: begin
            nxt_count = count_add(cur_count, 2'd1);
            if (code_byte[5:3] == 3'd0) begin
               if (cur_g3 == 2'd1) rem = rem + 6'd1;
               else if (cur_g3 == 2'd2) rem = rem + osz;
            end
            if (md == 2'd1) rem = rem + 6'd1;
            else if (md == 2'd2 || (md == 2'd0 && rm == 3'd5)) rem = rem + 6'd4;
            if (md != 2'd3 && rm == 3'd4) begin
               nxt_mod = md;
               nxt_rem = rem[4:0];
               nxt_phase = PH_SIB;
            end else done = 1'b1;
         end
         PH_SIB: begin
            nxt_count = count_add(cur_count, 2'd1);
            if (cur_mod == 2'd0 && rm == 3'd5) rem = rem + 6'd4;
            done = 1'b1;
         end
         PH_TAIL: begin
            nxt_count = count_add(cur_count, 2'd1);
            nxt_rem = (cur_rem != 5'd0) ? cur_rem - 5'd1 : 5'd0;
            if (nxt_rem == 5'd0) begin
               emit = 1'b1;
               result.length = nxt_count;
            end
         end
         default: begin
            if (cur_phase != PH_ESC && code_byte == 8'h66) begin
               nxt_op16 = 1'b1;
               nxt_count = count_add(cur_count, 2'd1);
            end else if (cur_phase != PH_ESC && prefix) begin
               nxt_count = count_add(cur_count, 2'd1);
            end else if (cur_phase != PH_ESC && code_byte == 8'h0F) begin
               nxt_phase = PH_ESC;
            end else begin
               nxt_g3 = (cur_phase == PH_ESC) ? 2'd0 :
                        (code_byte == 8'hF6) ? 2'd1 : (code_byte == 8'hF7) ? 2'd2 : 2'd0;
               if ((entry & E_BAD) != 8'd0) begin
                  emit = 1'b1;
                  result.invalid = 1'b1;
               end else begin
                  nxt_count = count_add(cur_count, opbytes[1:0]);
                  rem = ({2'd0, entry[3:0]} > opbytes) ? {2'd0, entry[3:0]} - opbytes : 6'd0;
                  if ((entry & E_OS) != 8'd0) rem = rem + osz;
                  if ((entry & E_MR) != 8'd0) begin
                     nxt_rem = rem[4:0];
                     nxt_phase = PH_MODRM;
                  end else done = 1'b1;
               end
            end
         end
      endcase
      if (done) begin
         if (rem == 6'd0) begin
            emit = 1'b1;
            result.length = nxt_count;
         end else begin
            nxt_rem = rem[4:0];
            nxt_phase = PH_TAIL;
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/x86_instruction_length_decoder.sv =====
// x86 instruction length pre-decoder, one code byte per item.
// A result item appears in the cycle after the byte that ends the instruction is taken.
// Throughput: one byte per cycle while no result waits untaken; the next state is combinational.
// A result item that waits untaken holds off the next byte; one taken in that cycle does not.
// Reset (synchronous, active high) returns the decoder to the prefix phase
// with all counts cleared and the result register empty.
`default_nettype none
module x86_instruction_length_decoder (
   input wire logic     clock,
   input wire logic     reset,
   xild_stream_if.sink  req,
   xild_stream_if.source rsp
);
   import xild_pkg::*;

   phase_type  phase_ff, phase_in;
   logic       op16_ff, op16_in;
   logic [5:0] count_ff, count_in;
   logic [4:0] rem_ff, rem_in;
   logic [1:0] g3_ff, g3_in;
   logic [1:0] mod_ff, mod_in;
   logic       emit;
   rsp_type    result;
   logic       valid_ff;
   rsp_type    data_ff;
   logic       take;

   // Ready is high whenever the result slot is free or drains this cycle.
   assign req.ready = !valid_ff || rsp.ready;
   assign take = req.valid && req.ready;
   assign rsp.valid = valid_ff;
   assign rsp.data = data_ff;

   xild_step u_step (
      .cur_phase(phase_ff), .code_byte(req.data), .cur_op16(op16_ff),
      .cur_count(count_ff), .cur_rem(rem_ff), .cur_g3(g3_ff), .cur_mod(mod_ff),
      .nxt_phase(phase_in), .nxt_op16(op16_in), .nxt_count(count_in),
      .nxt_rem(rem_in), .nxt_g3(g3_in), .nxt_mod(mod_in),
      .emit(emit), .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX;
         op16_ff <= 1'b0;
         count_ff <= '0;
         rem_ff <= '0;
         g3_ff <= '0;
         mod_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         // The result slot fills on an emitting byte and empties when taken.
         if (take && emit) valid_ff <= 1'b1;
         else if (rsp.ready) valid_ff <= 1'b0;
         if (take) begin
            if (emit) begin
               // Every emitted item ends the instruction and restarts the decoder.
               phase_ff <= PH_PREFIX;
               op16_ff <= 1'b0;
               count_ff <= '0;
               rem_ff <= '0;
               g3_ff <= '0;
               mod_ff <= '0;
            end else begin
               phase_ff <= phase_in;
               op16_ff <= op16_in;
               count_ff <= count_in;
               rem_ff <= rem_in;
               g3_ff <= g3_in;
               mod_ff <= mod_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) data_ff <= result;
   end
endmodule
`default_nettype wire

// ===== rtl/core/xild_checker.sv =====
// Port-level checks for the instruction length decoder, bound to the top level.
// Depends on x86_instruction_length_decoder, whose interface ports the bind reads.
`default_nettype none
module xild_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [5:0] rsp_length,
   input wire logic rsp_invalid
);
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("ready low with empty result slot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_length))
      else $error("stalled result changed");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_invalid |-> rsp_length != 6'd0)
      else $error("valid instruction of zero length");
endmodule

bind x86_instruction_length_decoder xild_checker u_xild_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_length(rsp.data.length),
   .rsp_invalid(rsp.data.invalid)
);
`default_nettype wire

// ===== test/tb_x86_instruction_length_decoder.sv =====
// Testbench for the x86 instruction length decoder: drives code bytes,
// predicts lengths with its own tables, and checks every result item.
// Depends on xild_pkg and xild_stream_if from the RTL.
`default_nettype none
module tb_x86_instruction_length_decoder;
   timeunit 1ns;
   timeprecision 1ps;
   import xild_pkg::*;

   // Flags of an opcode table entry, as the block defines them.
   localparam logic [7:0] F_MODRM = 8'h10;
   localparam logic [7:0] F_OPSZ  = 8'h20;
   localparam logic [7:0] F_BAD   = 8'h40;

   // Decode phases of the predictor.
   typedef enum logic [2:0] {
      ST_OPCODE, ST_ESCAPE, ST_MODRM, ST_SIB, ST_TAIL
   } dec_state_type;

   // The scoreboard keeps the predicted result items in order and
   // compares each result item that the decoder hands over.
   class length_scoreboard;
      rsp_type    pending_lengths[$];
      int         errors;
      dec_state_type st;
      bit         opsz16;
      logic [5:0] count;
      logic [4:0] remain;
      logic [1:0] grp3;
      logic [1:0] sib_mod;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         st = ST_OPCODE;
         opsz16 = 0;
         count = 0;
         remain = 0;
         grp3 = 0;
         sib_mod = 0;
      endfunction

      function logic [5:0] bump(logic [5:0] c, int n);
         int s;
         s = c + n;
         return (s > 63) ? 6'd63 : s[5:0];
      endfunction

      function void push_length(logic [5:0] len, bit bad);
         rsp_type r;
         r.length = len;
         r.invalid = bad;
         pending_lengths.push_back(r);
         clear();
      endfunction

      // One-byte opcode map, written out by ranges.
      function logic [7:0] primary_entry(logic [7:0] b);
         if (b < 8'h40) begin
            if (b == 8'h0F) return 8'd0;
            case (b % 8)
               4: return 8'd2;
               5: return F_OPSZ + 8'd1;
               6, 7: return 8'd1;
               default: return F_MODRM + 8'd1;
            endcase
         end
         if (b == 8'h62 || b == 8'h63) return F_MODRM + 8'd1;
         if (b == 8'h67 || b == 8'hD6 || b == 8'hF1) return F_BAD;
         if (b == 8'h68) return F_OPSZ + 8'd1;
         if (b == 8'h69) return F_MODRM + F_OPSZ + 8'd1;
         if (b == 8'h6A || b == 8'hA8 || b == 8'hCD || b == 8'hEB) return 8'd2;
         if (b == 8'h6B) return F_MODRM + 8'd2;
         if (b >= 8'h70 && b <= 8'h7F) return 8'd2;
         if (b == 8'h80 || b == 8'h82 || b == 8'h83) return F_MODRM + 8'd2;
         if (b == 8'h81 || b == 8'hC7) return F_MODRM + F_OPSZ + 8'd1;
         if (b >= 8'h84 && b <= 8'h8F) return F_MODRM + 8'd1;
         if (b == 8'h9A || b == 8'hEA) return F_OPSZ + 8'd3;
         if (b >= 8'hA0 && b <= 8'hA3) return 8'd5;
         if (b == 8'hA9) return F_OPSZ + 8'd1;
         if (b >= 8'hB0 && b <= 8'hB7) return 8'd2;
         if (b >= 8'hB8 && b <= 8'hBF) return F_OPSZ + 8'd1;
         if (b == 8'hC0 || b == 8'hC1 || b == 8'hC6) return F_MODRM + 8'd2;
         if (b == 8'hC2 || b == 8'hCA) return 8'd3;
         if (b == 8'hC4 || b == 8'hC5) return F_MODRM + 8'd1;
         if (b == 8'hC8) return 8'd4;
         if (b >= 8'hD0 && b <= 8'hD3) return F_MODRM + 8'd1;
         if (b == 8'hD4 || b == 8'hD5) return 8'd2;
         if (b >= 8'hD8 && b <= 8'hDF) return F_MODRM + 8'd1;
         if (b >= 8'hE0 && b <= 8'hE7) return 8'd2;
         if (b == 8'hE8 || b == 8'hE9) return F_OPSZ + 8'd1;
         if (b == 8'hF6 || b == 8'hF7 || b == 8'hFE || b == 8'hFF) return F_MODRM + 8'd1;
         return 8'd1;
      endfunction

      // Map that follows the 0F escape.
      function logic [7:0] secondary_entry(logic [7:0] b);
         if (b <= 8'h03) return F_MODRM + 8'd2;
         if (b == 8'h06 || b == 8'h08 || b == 8'h09) return 8'd2;
         if ((b >= 8'h20 && b <= 8'h24) || b == 8'h26) return 8'd3;
         if (b >= 8'h30 && b <= 8'h32) return 8'd2;
         if (b >= 8'h80 && b <= 8'h8F) return F_OPSZ + 8'd2;
         if (b >= 8'h90 && b <= 8'h9F) return F_MODRM + 8'd2;
         if (b == 8'hA0 || b == 8'hA1 || b == 8'hA2 || b == 8'hA8 || b == 8'hA9 ||
             b == 8'hAA) return 8'd2;
         if (b == 8'hA3 || b == 8'hA5 || b == 8'hAB || b == 8'hAD || b == 8'hAF)
            return F_MODRM + 8'd2;
         if (b == 8'hA4 || b == 8'hAC || b == 8'hBA) return F_MODRM + 8'd3;
         if ((b >= 8'hB0 && b <= 8'hB7) || (b >= 8'hBB && b <= 8'hBF) ||
             b == 8'hC0 || b == 8'hC1) return F_MODRM + 8'd2;
         if (b >= 8'hC8 && b <= 8'hCF) return 8'd2;
         return F_BAD;
      endfunction

      function void finish_or_tail(int rem);
         if (rem == 0) push_length(count, 0);
         else begin
            remain = rem[4:0];
            st = ST_TAIL;
         end
      endfunction

      function void apply_entry(logic [7:0] e, int opbytes);
         int base, rem;
         if (e & F_BAD) begin
            push_length(count, 1);
            return;
         end
         base = e & 8'h0F;
         count = bump(count, opbytes);
         rem = (base > opbytes) ? base - opbytes : 0;
         if (e & F_OPSZ) rem += opsz16 ? 2 : 4;
         if (e & F_MODRM) begin
            remain = rem[4:0];
            st = ST_MODRM;
         end else finish_or_tail(rem);
      endfunction

      // Notes one accepted code byte and predicts what it causes.
      function void note_byte(logic [7:0] b);
         int rem;
         case (st)
            ST_ESCAPE: begin
               grp3 = 0;
               apply_entry(secondary_entry(b), 2);
            end
            ST_MODRM: begin
               count = bump(count, 1);
               rem = remain;
               if (b[5:3] == 0) begin
                  if (grp3 == 1) rem += 1;
                  else if (grp3 == 2) rem += opsz16 ? 2 : 4;
               end
               if (b[7:6] == 1) rem += 1;
               else if (b[7:6] == 2) rem += 4;
               else if (b[7:6] == 0 && b[2:0] == 5) rem += 4;
               if (b[7:6] != 3 && b[2:0] == 4) begin
                  sib_mod = b[7:6];
                  remain = rem[4:0];
                  st = ST_SIB;
               end else finish_or_tail(rem);
            end
            ST_SIB: begin
               count = bump(count, 1);
               rem = remain;
               if (sib_mod == 0 && b[2:0] == 5) rem += 4;
               finish_or_tail(rem);
            end
            ST_TAIL: begin
               count = bump(count, 1);
               if (remain > 0) remain--;
               if (remain == 0) push_length(count, 0);
            end
            default: begin
               if (b == 8'h66) begin
                  opsz16 = 1;
                  count = bump(count, 1);
               end else if (b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h26 ||
                            b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h64 ||
                            b == 8'h65) begin
                  count = bump(count, 1);
               end else if (b == 8'h0F) begin
                  st = ST_ESCAPE;
               end else begin
                  grp3 = (b == 8'hF6) ? 1 : ((b == 8'hF7) ? 2 : 0);
                  apply_entry(primary_entry(b), 1);
               end
            end
         endcase
      endfunction

      // Compares one result item with the oldest prediction.
      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_lengths.size() == 0) begin
            $display("%0t: unexpected result length=%0d invalid=%0d",
                     $time, got.length, got.invalid);
            errors++;
            return;
         end
         want = pending_lengths.pop_front();
         if (got.length !== want.length) begin
            $display("%0t: length mismatch expected %0d actual %0d",
                     $time, want.length, got.length);
            errors++;
         end
         if (got.invalid !== want.invalid) begin
            $display("%0t: invalid mismatch expected %0d actual %0d",
                     $time, want.invalid, got.invalid);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   xild_stream_if #(.PAYLOAD_TYPE(logic [7:0])) req_if ();
   xild_stream_if #(.PAYLOAD_TYPE(rsp_type))    rsp_if ();

   x86_instruction_length_decoder uut (
      .clock(clock),
      .reset(reset),
      .req  (req_if.sink),
      .rsp  (rsp_if.source)
   );

   length_scoreboard sb;
   logic [7:0] byte_stream[$];   // code bytes still to be offered
   bit         long_hold;        // the receiver holds off while this is set

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watchdog: far beyond the slowest correct run of a few thousand bytes.
   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

   // Both channels are sampled at the rising edge, before the nonblocking
   // updates of the drivers take effect, so the order of processes is moot.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) sb.note_byte(req_if.data);
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
   end

   // Receiver: a stall pattern of its own, plus the long hold-off.
   initial begin
      int phase_ctr;
      phase_ctr = 0;
      rsp_if.ready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) rsp_if.ready <= 0;
         else if (phase_ctr < 200) rsp_if.ready <= 1;
         else rsp_if.ready <= (phase_ctr % 7 != 3) && ($urandom_range(0, 3) != 0);
         phase_ctr = (phase_ctr + 1) % 600;
         @(posedge clock);
      end
   end

   // Sender: bursts of random length from the byte stream, random gaps.
   initial begin
      int burst, gap;
      req_if.valid = 0;
      req_if.data = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         burst = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         while (burst > 0 && byte_stream.size() > 0) begin
            req_if.valid <= 1;
            req_if.data <= byte_stream[0];
            @(posedge clock);
            if (req_if.ready) begin
               void'(byte_stream.pop_front());
               burst--;
            end
         end
         // Valid drops only where a gap follows or nothing is left to send.
         if (gap > 0 || byte_stream.size() == 0) req_if.valid <= 0;
         repeat (gap) @(posedge clock);
         if (byte_stream.size() == 0) @(posedge clock);
      end
   end

   // Appends a random instruction: optional prefixes, an optional 0F or F6/F7, an opcode, trailing bytes.
   task automatic queue_instruction();
      logic [7:0] prefixes[$];
      int n;
      prefixes = '{8'h66, 8'hF0, 8'hF2, 8'hF3, 8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65};
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) byte_stream.push_back(prefixes[$urandom_range(0, 9)]);
      case ($urandom_range(0, 5))
         0: byte_stream.push_back(8'h0F);
         1: byte_stream.push_back($urandom_range(0, 1) ? 8'hF6 : 8'hF7);
         default: ;
      endcase
      byte_stream.push_back($urandom_range(0, 255));
      // Trailing random bytes cover ModRM, SIB and immediates; leftovers
      // simply start the next instruction, which keeps the stream legal.
      repeat ($urandom_range(0, 6)) byte_stream.push_back($urandom_range(0, 255));
   endtask

   task automatic wait_drained();
      while (byte_stream.size() > 0 || req_if.valid) @(posedge clock);
      while (sb.pending_lengths.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      sb = new();
      long_hold = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: prefix runs, both maps, invalid opcodes, ModRM forms,
      // SIB with a bare displacement, group-3 immediates, saturation.
      byte_stream = '{8'h90, 8'h00, 8'h00, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44,
                      8'h66, 8'hB8, 8'h12, 8'h34, 8'h67, 8'hF0, 8'hD6, 8'hF1,
                      8'h0F, 8'hFF, 8'h66, 8'h0F, 8'h85, 8'h01, 8'h02,
                      8'hF6, 8'h00, 8'h7E, 8'hF7, 8'h04, 8'h25, 8'h01, 8'h02,
                      8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
                      8'h8B, 8'h44, 8'h24, 8'h08, 8'h8B, 8'hC0, 8'h0F, 8'hA4,
                      8'h80, 8'h10, 8'hEA, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
      repeat (70) byte_stream.push_back(8'h2E);
      byte_stream.push_back(8'hC3);
      repeat (64) byte_stream.push_back(8'h66);
      byte_stream.push_back(8'h67);
      wait_drained();

      // Random part, with a long receiver hold-off in the middle.
      for (int i = 0; i < 200; i++) begin
         if ($urandom_range(0, 9) == 0) byte_stream.push_back($urandom_range(0, 255));
         else queue_instruction();
         if (i == 100) begin
            long_hold = 1;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         if (byte_stream.size() > 60) while (byte_stream.size() > 10) @(posedge clock);
      end
      wait_drained();

      if (sb.errors == 0 && sb.pending_lengths.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
